// ===== hw/rtl/lom_pkg.sv =====
// Package for the lidar occupancy marker: payload types, codes, constants.
// No dependencies; used by every module of the block.
package lom_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;
    localparam int ROW_W      = $clog2(MAP_HEIGHT);
    localparam int COL_W      = $clog2(MAP_WIDTH);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELLS      = MAP_WIDTH * MAP_HEIGHT;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] MODE_MARK = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;

    localparam logic [2:0] ST_WRITTEN = 3'd0;
    localparam logic [2:0] ST_TOO_FAR = 3'd1;
    localparam logic [2:0] ST_OFF_MAP = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [2:0] REG_MAX_RANGE = 3'd0;
    localparam logic [2:0] REG_START     = 3'd1;
    localparam logic [2:0] REG_STEP      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd4;
    localparam logic [2:0] REG_CELL_SIZE = 3'd5;
    localparam logic [2:0] REG_OCCUPIED  = 3'd6;
    localparam logic [2:0] REG_UNKNOWN   = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         beam_index;
        logic [15:0]        beam_depth;
        logic [15:0]        heading;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [7:0]         read_row;
        logic [7:0]         read_col;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] cell_value;
    } t_out;

    typedef enum logic [1:0] {
        K_MARK, K_READ, K_CLEAR, K_DONE
    } t_kind;

    // Classified command between front and back
    typedef struct packed {
        t_kind              kind;
        logic [2:0]         status;
        logic [15:0]        angle;
        logic [15:0]        depth;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [7:0]         row;
        logic [7:0]         col;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        max_range;
        logic [15:0]        start_angle;
        logic [15:0]        angle_step;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [15:0]        cell_size;
        logic [7:0]         occupied_value;
        logic [7:0]         unknown_value;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_MUL, S_SUM, S_DIVSET, S_DIV, S_CHECK,
        S_WRITE, S_RDREQ, S_RDWAIT, S_CLEAR, S_OUT
    } t_state;

    function automatic logic signed [20:0] atan_lut(input logic [3:0] i);
        logic signed [20:0] v;
        case (i)
            4'd0:  v = 21'sd131072;
            4'd1:  v = 21'sd77376;
            4'd2:  v = 21'sd40884;
            4'd3:  v = 21'sd20753;
            4'd4:  v = 21'sd10417;
            4'd5:  v = 21'sd5213;
            4'd6:  v = 21'sd2607;
            4'd7:  v = 21'sd1304;
            4'd8:  v = 21'sd652;
            4'd9:  v = 21'sd326;
            4'd10: v = 21'sd163;
            4'd11: v = 21'sd81;
            4'd12: v = 21'sd41;
            4'd13: v = 21'sd20;
            4'd14: v = 21'sd10;
            default: v = 21'sd5;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/lom_front.sv =====
// Front end: accepts transactions, checks range, forms the beam angle.
// Depends on lom_pkg.
module lom_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lom_pkg::t_in   i_data,
    input  lom_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_stall,
    output lom_pkg::t_cmd  o_cmd
);
    lom_pkg::t_cmd r_cmd, n_cmd;
    logic          r_valid;
    logic [25:0]   w_prod;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign w_prod  = i_data.beam_index * i_cfg.angle_step;

    // Classify the incoming transaction
    always_comb begin
        n_cmd        = '0;
        n_cmd.kind   = lom_pkg::K_MARK;
        n_cmd.depth  = i_data.beam_depth;
        n_cmd.pose_x = i_data.pose_x;
        n_cmd.pose_y = i_data.pose_y;
        n_cmd.angle  = i_cfg.start_angle + w_prod[15:0] + i_data.heading;
        if (i_data.mode[1]) begin
            n_cmd.kind = lom_pkg::K_CLEAR;
        end else if (i_data.mode == lom_pkg::MODE_READ) begin
            n_cmd.kind = lom_pkg::K_READ;
            n_cmd.row  = i_data.read_row;
            n_cmd.col  = i_data.read_col;
            if (32'(i_data.read_row) >= 32'(lom_pkg::MAP_HEIGHT) ||
                32'(i_data.read_col) >= 32'(lom_pkg::MAP_WIDTH)) begin
                n_cmd.kind   = lom_pkg::K_DONE;
                n_cmd.status = lom_pkg::ST_OFF_MAP;
                n_cmd.row    = '0;
                n_cmd.col    = '0;
            end
        end else if (i_data.beam_depth > i_cfg.max_range) begin
            n_cmd.kind   = lom_pkg::K_DONE;
            n_cmd.status = lom_pkg::ST_TOO_FAR;
        end
    end

    // Hold the classified command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// ===== hw/rtl/lom_queue.sv =====
// Short queue between front and back ends.
// Depends on lom_pkg.
module lom_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lom_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output lom_pkg::t_cmd  o_cmd
);
    localparam int PW = $clog2(lom_pkg::QDEPTH);
    lom_pkg::t_cmd r_mem [lom_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_stall = (r_cnt == (PW+1)'(lom_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

// ===== hw/rtl/lom_back.sv =====
// Back end: CORDIC, projection, serial divide, grid memory and result register.
// Depends on lom_pkg.
module lom_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lom_pkg::t_cmd  i_cmd,
    input  lom_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_stall,
    output lom_pkg::t_out  o_data
);
    lom_pkg::t_state r_state, n_state;
    lom_pkg::t_cmd   r_cmd;
    lom_pkg::t_out   r_out;
    logic            r_ovalid;
    logic            r_neg;
    logic signed [20:0] r_z;
    logic signed [19:0] r_cx, r_cy;
    logic [3:0]      r_it;
    logic signed [15:0] r_cos, r_sin;
    logic signed [33:0] r_mx, r_my;
    logic signed [25:0] r_nx, r_ny;   // numerators origin - point
    logic [25:0]     r_qx, r_qy, r_rx, r_ry;
    logic [4:0]      r_dc;
    logic            r_sx, r_sy;
    logic [lom_pkg::ADDR_W-1:0] r_addr;
    logic [7:0]      r_rd;
    logic [7:0]      r_mem [lom_pkg::CELLS];
    logic [lom_pkg::ROW_W-1:0] r_row;
    logic [lom_pkg::COL_W-1:0] r_col;

    logic signed [20:0] w_z0, w_z1;
    logic               w_neg;
    logic signed [19:0] w_xs, w_ys;
    logic [15:0]        w_div;
    logic [26:0]        w_tx, w_ty;
    logic signed [26:0] w_rowv, w_colv;
    logic signed [19:0] w_fx, w_fy;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign o_stall = (r_state != lom_pkg::S_IDLE) || r_ovalid;
    assign w_div   = (i_cfg.cell_size == '0) ? 16'd1 : i_cfg.cell_size;

    // Fold the angle into a quarter turn
    always_comb begin
        // sign-extend: the upper half turn becomes negative
        w_z0  = 21'($signed({i_cmd.angle, 4'b0}));
        w_neg = 1'b0;
        w_z1  = w_z0;
        if (w_z0 > 21'sd262144) begin
            w_z1 = w_z0 - 21'sd524288;
            w_neg = 1'b1;
        end else if (w_z0 < -21'sd262144) begin
            w_z1 = w_z0 + 21'sd524288;
            w_neg = 1'b1;
        end
        w_xs = r_cx >>> r_it;
        w_ys = r_cy >>> r_it;
        w_fx = r_neg ? -r_cx : r_cx;
        w_fy = r_neg ? -r_cy : r_cy;
        w_tx = {r_rx, r_qx[25]} - {11'b0, w_div};
        w_ty = {r_ry, r_qy[25]} - {11'b0, w_div};
        w_rowv = r_sx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
        w_colv = r_sy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lom_pkg::S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    unique case (i_cmd.kind)
                        lom_pkg::K_MARK:  n_state = lom_pkg::S_CORDIC;
                        lom_pkg::K_READ:  n_state = lom_pkg::S_RDREQ;
                        lom_pkg::K_CLEAR: n_state = lom_pkg::S_CLEAR;
                        default:          n_state = lom_pkg::S_OUT;
                    endcase
                end
            end
            lom_pkg::S_CORDIC: if (r_it == 4'd15) n_state = lom_pkg::S_MUL;
            lom_pkg::S_MUL:    n_state = lom_pkg::S_SUM;
            lom_pkg::S_SUM:    n_state = lom_pkg::S_DIVSET;
            lom_pkg::S_DIVSET: n_state = lom_pkg::S_DIV;
            lom_pkg::S_DIV:    if (r_dc == 5'd25) n_state = lom_pkg::S_CHECK;
            lom_pkg::S_CHECK:  n_state = lom_pkg::S_WRITE;
            lom_pkg::S_WRITE:  n_state = lom_pkg::S_OUT;
            lom_pkg::S_RDREQ:  n_state = lom_pkg::S_RDWAIT;
            lom_pkg::S_RDWAIT: n_state = lom_pkg::S_OUT;
            lom_pkg::S_CLEAR:
                if (r_addr == {lom_pkg::ADDR_W{1'b1}}) n_state = lom_pkg::S_OUT;
            lom_pkg::S_OUT:    n_state = lom_pkg::S_IDLE;
            default:           n_state = lom_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lom_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == lom_pkg::S_OUT)  r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall)  r_ovalid <= 1'b0;
        end
        unique case (r_state)
            lom_pkg::S_IDLE: begin
                // Hold the waiting result; load only once it has gone
                if (!r_ovalid) begin
                    r_cmd  <= i_cmd;
                    r_z    <= w_z1;
                    r_neg  <= w_neg;
                    r_cx   <= 20'sd19898;
                    r_cy   <= '0;
                    r_it   <= '0;
                    r_addr <= '0;
                    r_out  <= '{status: i_cmd.status, cell_row: '0, cell_col: '0,
                                cell_value: '0};
                end
            end
            lom_pkg::S_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_z  <= r_z - lom_pkg::atan_lut(r_it);
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_z  <= r_z + lom_pkg::atan_lut(r_it);
                end
                r_it <= r_it + 1'b1;
            end
            lom_pkg::S_MUL: begin
                r_cos <= (w_fx > 20'sd32767) ? 16'sh7fff :
                         (w_fx < -20'sd32768) ? -16'sh8000 : w_fx[15:0];
                r_sin <= (w_fy > 20'sd32767) ? 16'sh7fff :
                         (w_fy < -20'sd32768) ? -16'sh8000 : w_fy[15:0];
            end
            lom_pkg::S_SUM: begin
                r_mx <= $signed({1'b0, r_cmd.depth}) * r_cos;
                r_my <= $signed({1'b0, r_cmd.depth}) * r_sin;
            end
            lom_pkg::S_DIVSET: begin
                r_nx <= 26'(i_cfg.origin_x) - 26'(r_cmd.pose_x) - 26'(r_mx >>> 15);
                r_ny <= 26'(i_cfg.origin_y) - 26'(r_cmd.pose_y) - 26'(r_my >>> 15);
                r_dc <= '0;
                r_rx <= '0;
                r_ry <= '0;
            end
            lom_pkg::S_DIV: begin
                if (r_dc == 5'd0) begin
                    // Load magnitudes on the first step, then shift one bit a cycle
                    r_sx <= r_nx[25];
                    r_sy <= r_ny[25];
                    r_qx <= r_nx[25] ? 26'(-r_nx) : 26'(r_nx);
                    r_qy <= r_ny[25] ? 26'(-r_ny) : 26'(r_ny);
                end else begin
                    if (!w_tx[26]) begin
                        r_rx <= w_tx[25:0];
                        r_qx <= {r_qx[24:0], 1'b1};
                    end else begin
                        r_rx <= {r_rx[24:0], r_qx[25]};
                        r_qx <= {r_qx[24:0], 1'b0};
                    end
                    if (!w_ty[26]) begin
                        r_ry <= w_ty[25:0];
                        r_qy <= {r_qy[24:0], 1'b1};
                    end else begin
                        r_ry <= {r_ry[24:0], r_qy[25]};
                        r_qy <= {r_qy[24:0], 1'b0};
                    end
                end
                r_dc <= r_dc + 1'b1;
            end
            lom_pkg::S_CHECK: begin
                // final shift: one more step completes 26 quotient bits
                if (!w_tx[26]) r_qx <= {r_qx[24:0], 1'b1};
                else           r_qx <= {r_qx[24:0], 1'b0};
                if (!w_ty[26]) r_qy <= {r_qy[24:0], 1'b1};
                else           r_qy <= {r_qy[24:0], 1'b0};
            end
            lom_pkg::S_WRITE: begin
                if (w_rowv < 0 || w_rowv >= 27'(lom_pkg::MAP_HEIGHT) ||
                    w_colv < 0 || w_colv >= 27'(lom_pkg::MAP_WIDTH)) begin
                    r_out.status <= lom_pkg::ST_OFF_MAP;
                end else begin
                    r_out.status   <= lom_pkg::ST_WRITTEN;
                    r_out.cell_row <= 8'(w_rowv);
                    r_out.cell_col <= 8'(w_colv);
                    r_mem[{w_rowv[lom_pkg::ROW_W-1:0], w_colv[lom_pkg::COL_W-1:0]}]
                        <= i_cfg.occupied_value;
                end
            end
            lom_pkg::S_RDREQ: begin
                r_rd <= r_mem[{r_row, r_col}];
            end
            lom_pkg::S_RDWAIT: begin
                r_out.status     <= lom_pkg::ST_READ;
                r_out.cell_row   <= r_cmd.row;
                r_out.cell_col   <= r_cmd.col;
                r_out.cell_value <= r_rd;
            end
            lom_pkg::S_CLEAR: begin
                r_mem[r_addr] <= i_cfg.unknown_value;
                r_addr <= r_addr + 1'b1;
                r_out.status <= lom_pkg::ST_CLEARED;
            end
            default: ;
        endcase
    end

    assign r_row = r_cmd.row[lom_pkg::ROW_W-1:0];
    assign r_col = r_cmd.col[lom_pkg::COL_W-1:0];

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_out))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lom_pkg::S_OUT |-> !r_ovalid)
        else $error("result overwritten");
    a_wr_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_out.status <= lom_pkg::ST_CLEARED)
        else $error("bad status");
`endif
endmodule

// ===== hw/rtl/lidar_occupancy_marker.sv =====
// Lidar occupancy marker: from input transaction to result, a mark passes through 16 CORDIC
// steps and a 26-step divide.
// The back end holds one item and takes the next the cycle after its result is taken;
// the front register and queue accept up to three ahead.
// Reset is synchronous, active low. The grid is then swept to unknown_value (its result
// swallowed); items are accepted meanwhile and wait behind it.
module lidar_occupancy_marker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lom_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output lom_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);
    lom_pkg::t_cfg r_cfg;
    logic          f_valid, f_stall, q_valid, q_stall;
    lom_pkg::t_cmd f_cmd, q_cmd, b_cmd;
    logic          r_init;
    logic          w_fvalid, w_bvalid;
    logic          w_fstall;
    logic          q_stall_b;
    logic          b_ovalid;
    lom_pkg::t_out b_data;
    logic          r_drop;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_range      <= 16'hffff;
            r_cfg.start_angle    <= '0;
            r_cfg.angle_step     <= 16'd64;
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.cell_size      <= 16'd26;
            r_cfg.occupied_value <= '0;
            r_cfg.unknown_value  <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lom_pkg::REG_MAX_RANGE: r_cfg.max_range      <= i_cfg_data[15:0];
                lom_pkg::REG_START:     r_cfg.start_angle    <= i_cfg_data[15:0];
                lom_pkg::REG_STEP:      r_cfg.angle_step     <= i_cfg_data[15:0];
                lom_pkg::REG_ORIGIN_X:  r_cfg.origin_x       <= i_cfg_data;
                lom_pkg::REG_ORIGIN_Y:  r_cfg.origin_y       <= i_cfg_data;
                lom_pkg::REG_CELL_SIZE: r_cfg.cell_size      <= i_cfg_data[15:0];
                lom_pkg::REG_OCCUPIED:  r_cfg.occupied_value <= i_cfg_data[7:0];
                lom_pkg::REG_UNKNOWN:   r_cfg.unknown_value  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Inject a clear after reset; the clear's result is swallowed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                  r_init <= 1'b1;
        else if (!q_stall && r_init)   r_init <= 1'b0;
    end

    assign w_fvalid = i_valid && !r_init;
    assign o_stall  = f_stall || r_init;
    assign w_fstall = r_init ? 1'b1 : q_stall;

    always_comb begin
        b_cmd      = f_cmd;
        b_cmd.kind = r_init ? lom_pkg::K_CLEAR : f_cmd.kind;
    end
    assign w_bvalid = r_init || f_valid;

    lom_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(w_fvalid), .o_stall(f_stall), .i_data,
        .i_cfg(r_cfg),
        .o_valid(f_valid), .i_stall(w_fstall), .o_cmd(f_cmd)
    );

    lom_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_bvalid), .o_stall(q_stall), .i_cmd(b_cmd),
        .o_valid(q_valid), .i_stall(q_stall_b), .o_cmd(q_cmd)
    );

    // The first result after reset belongs to the start-up clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                r_drop <= 1'b1;
        else if (b_ovalid && r_drop) r_drop <= 1'b0;
    end
    assign o_valid = b_ovalid && !r_drop;
    assign o_data  = b_data;

    lom_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(q_stall_b), .i_cmd(q_cmd),
        .i_cfg(r_cfg),
        .o_valid(b_ovalid), .i_stall(i_stall && !r_drop), .o_data(b_data)
    );
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for lidar_occupancy_marker: sends mark/read/clear transactions,
// predicts every result with an in-bench grid and fixed-point model, compares field-wise.
// Depends on lom_pkg and the lidar_occupancy_marker RTL.
module tb_top;

    localparam logic [1:0] MODE_CLEAR     = 2'd2;
    localparam logic [1:0] MODE_CLEAR_ALT = 2'd3;
    localparam int         CYCLE_LIMIT    = 3000000;
    localparam int         DRAIN_CYCLES   = 80;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         ARCTAN [16]    = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                              1304, 652, 326, 163, 81, 41, 20, 10, 5};

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    lom_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    lom_pkg::t_out o_data;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_idx;
    logic [23:0]   i_cfg_data;

    logic          rx_stall;
    logic          hold_off;
    bit            hold_req;
    bit            rx_took;
    int            rx_gap;
    int            rx_max;
    int            tx_max;
    int            errors;
    int            cycles;
    lom_pkg::t_out expect_q [$];
    lom_pkg::t_cfg cfg_m;
    logic [7:0]    grid_m [lom_pkg::CELLS];

    lidar_occupancy_marker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    assign i_stall = rx_stall | hold_off;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction
    function automatic void beam_sin_cos(input logic [15:0] a, output int s, output int c);
        int z, x, y, xs, ys;
        bit neg;
        z = int'({a, 4'b0000});
        x = 19898;
        y = 0;
        neg = 1'b0;
        if (z >= (1 << 19)) z -= (1 << 20);
        // fold the half turn away, negate at the end
        if (z > (1 << 18)) begin
            z -= (1 << 19);
            neg = 1'b1;
        end else if (z < -(1 << 18)) begin
            z += (1 << 19);
            neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARCTAN[i];
            end else begin
                x += ys; y -= xs; z += ARCTAN[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
        s = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
    endfunction

    function automatic lom_pkg::t_out predict_cell(input lom_pkg::t_in it);
        lom_pkg::t_out r;
        logic [15:0]   ang;
        int            s, c;
        longint        wx, wy, row, col, div;
        r = '0;
        if (it.mode[1]) begin
            foreach (grid_m[k]) grid_m[k] = cfg_m.unknown_value;
            r.status = lom_pkg::ST_CLEARED;
        end else if (it.mode == lom_pkg::MODE_READ) begin
            r.status     = lom_pkg::ST_READ;
            r.cell_row   = it.read_row;
            r.cell_col   = it.read_col;
            r.cell_value = grid_m[{it.read_row, it.read_col}];
        end else if (it.beam_depth > cfg_m.max_range) begin
            r.status = lom_pkg::ST_TOO_FAR;
        end else begin
            ang = 16'(int'(cfg_m.start_angle) + int'(it.beam_index) * int'(cfg_m.angle_step)
                      + int'(it.heading));
            beam_sin_cos(ang, s, c);
            wx  = longint'(it.pose_x) + ((longint'(it.beam_depth) * longint'(c)) >>> 15);
            wy  = longint'(it.pose_y) + ((longint'(it.beam_depth) * longint'(s)) >>> 15);
            div = (cfg_m.cell_size == 0) ? 1 : longint'(cfg_m.cell_size);
            row = (longint'(cfg_m.origin_x) - wx) / div;
            col = (longint'(cfg_m.origin_y) - wy) / div;
            if (row < 0 || row >= lom_pkg::MAP_HEIGHT ||
                col < 0 || col >= lom_pkg::MAP_WIDTH) begin
                r.status = lom_pkg::ST_OFF_MAP;
            end else begin
                grid_m[row * lom_pkg::MAP_WIDTH + col] = cfg_m.occupied_value;
                r.status   = lom_pkg::ST_WRITTEN;
                r.cell_row = 8'(row);
                r.cell_col = 8'(col);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            rx_took = 1'b1;
            if (expect_q.size() == 0) begin
                report("unexpected transaction, status", o_data.status, -1);
            end else begin
                lom_pkg::t_out w;
                w = expect_q.pop_front();
                if (o_data.status !== w.status)         report("status", o_data.status, w.status);
                if (o_data.cell_row !== w.cell_row)     report("row", o_data.cell_row, w.cell_row);
                if (o_data.cell_col !== w.cell_col)     report("col", o_data.cell_col, w.cell_col);
                if (o_data.cell_value !== w.cell_value)
                    report("value", o_data.cell_value, w.cell_value);
            end
        end
    end

    // Draw a new receive stall after each accepted transaction
    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_gap  = $urandom_range(0, rx_max);
            rx_took = 1'b0;
        end
        if (rx_gap > 0) begin
            rx_stall = 1'b1;
            rx_gap--;
        end else begin
            rx_stall = 1'b0;
        end
    end

    // Long hold-off on the result side, counted here
    initial begin
        hold_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- driving
    task automatic send_item(input lom_pkg::t_in it);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data  = it;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expect_q.push_back(predict_cell(it));
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid = 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            lom_pkg::REG_MAX_RANGE: cfg_m.max_range      = val[15:0];
            lom_pkg::REG_START:     cfg_m.start_angle    = val[15:0];
            lom_pkg::REG_STEP:      cfg_m.angle_step     = val[15:0];
            lom_pkg::REG_ORIGIN_X:  cfg_m.origin_x       = val;
            lom_pkg::REG_ORIGIN_Y:  cfg_m.origin_y       = val;
            lom_pkg::REG_CELL_SIZE: cfg_m.cell_size      = val[15:0];
            lom_pkg::REG_OCCUPIED:  cfg_m.occupied_value = val[7:0];
            lom_pkg::REG_UNKNOWN:   cfg_m.unknown_value  = val[7:0];
            default: ;
        endcase
    endtask

    function automatic lom_pkg::t_in mark_item(input logic [15:0] depth,
                                               input logic [15:0] head,
                                               input int px, input int py,
                                               input logic [9:0] idx);
        lom_pkg::t_in it;
        it            = '0;
        it.mode       = lom_pkg::MODE_MARK;
        it.beam_index = idx;
        it.beam_depth = depth;
        it.heading    = head;
        it.pose_x     = 24'(px);
        it.pose_y     = 24'(py);
        return it;
    endfunction

    function automatic lom_pkg::t_in read_item(input logic [7:0] r, input logic [7:0] c);
        lom_pkg::t_in it;
        it          = lom_pkg::t_in'({$urandom, $urandom, $urandom, $urandom});
        it.mode     = lom_pkg::MODE_READ;
        it.read_row = r;
        it.read_col = c;
        return it;
    endfunction

    // ---------------------------------------------------------------- tests
    // Default registers: extremes of depth, pose and angle, read-back of written cells
    task automatic test_directed();
        lom_pkg::t_in it;
        send_item(read_item(8'd0, 8'd0));
        send_item(mark_item(16'd0, 16'd0, 0, 0, 10'd0));
        send_item(read_item(8'd0, 8'd0));
        send_item(read_item(8'd255, 8'd255));
        send_item(mark_item(16'd1, 16'd0, -25, -25, 10'd0));
        send_item(mark_item(16'd65535, 16'd65535, -8388608, -8388608, 10'd1023));
        send_item(mark_item(16'd65535, 16'd16384, 8388607, 8388607, 10'd0));
        send_item(mark_item(16'd2000, 16'd32768, -3000, -3000, 10'd0));
        send_item(mark_item(16'd2000, 16'd49152, -3000, -3000, 10'd0));
        send_item(mark_item(16'd2000, 16'd16384, -3000, -3000, 10'd256));
        it          = mark_item(16'd100, 16'd0, -6600, -6600, 10'd0);
        it.read_row = 8'hFF;
        it.read_col = 8'hFF;
        send_item(it);
        send_item(read_item(8'd253, 8'd253));
        settle();
    endtask

    // Register extremes: too-far, zero cell size, both clear codes
    task automatic test_config_extremes();
        lom_pkg::t_in it;
        write_reg(lom_pkg::REG_MAX_RANGE, 24'd0);
        write_reg(lom_pkg::REG_CELL_SIZE, 24'd0);
        write_reg(lom_pkg::REG_OCCUPIED, 24'd255);
        write_reg(lom_pkg::REG_UNKNOWN, 24'd0);
        write_reg(lom_pkg::REG_START, 24'hFFFF);
        write_reg(lom_pkg::REG_STEP, 24'hFFFF);
        write_reg(lom_pkg::REG_ORIGIN_X, 24'h7FFFFF);
        write_reg(lom_pkg::REG_ORIGIN_Y, 24'h800000);
        send_item(mark_item(16'd1, 16'd0, 0, 0, 10'd5));
        send_item(mark_item(16'd0, 16'd1, 8388500, -8388600, 10'd1023));
        settle();
        write_reg(lom_pkg::REG_ORIGIN_Y, 24'h7FFFFF);
        send_item(mark_item(16'd0, 16'd0, 8388607 - 100, 8388607 - 255, 10'd0));
        send_item(read_item(8'd100, 8'd255));
        it      = '0;
        it.mode = MODE_CLEAR;
        send_item(it);
        send_item(read_item(8'd100, 8'd255));
        settle();
        write_reg(lom_pkg::REG_UNKNOWN, 24'd255);
        it      = lom_pkg::t_in'({$urandom, $urandom, $urandom, $urandom});
        it.mode = MODE_CLEAR_ALT;
        send_item(it);
        send_item(read_item(8'd7, 8'd9));
        settle();
        write_reg(lom_pkg::REG_MAX_RANGE, 24'd65535);
    endtask

    // A scan around the map centre with the given cell size; mostly marks that land
    task automatic test_random_scan(input int n, input int cs, input int depth_max,
                                    input bit with_clear);
        lom_pkg::t_in it;
        int           pick;
        write_reg(lom_pkg::REG_CELL_SIZE, 24'(cs));
        write_reg(lom_pkg::REG_ORIGIN_X, 24'(cs * 128 + $urandom_range(0, 40) - 20));
        write_reg(lom_pkg::REG_ORIGIN_Y, 24'(cs * 128 + $urandom_range(0, 40) - 20));
        write_reg(lom_pkg::REG_START, 24'($urandom_range(0, 65535)));
        write_reg(lom_pkg::REG_STEP, 24'($urandom_range(0, 700)));
        write_reg(lom_pkg::REG_MAX_RANGE, 24'($urandom_range(depth_max * 7 / 8, depth_max)));
        write_reg(lom_pkg::REG_OCCUPIED, 24'($urandom_range(0, 255)));
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (k % 150 == 0) begin
                tx_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
                rx_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
            end
            if (pick < 72) begin
                it = mark_item(16'($urandom_range(0, depth_max)), 16'($urandom),
                               $urandom_range(0, cs * 60) - cs * 30,
                               $urandom_range(0, cs * 60) - cs * 30,
                               10'($urandom));
            end else if (pick < 90) begin
                it = read_item(8'($urandom_range(100, 156)), 8'($urandom_range(100, 156)));
            end else if (pick < 95) begin
                it = read_item(8'($urandom), 8'($urandom));
            end else begin
                it      = lom_pkg::t_in'({$urandom, $urandom, $urandom, $urandom});
                it.mode = lom_pkg::MODE_MARK;
            end
            if (with_clear && k == n / 2) begin
                it.mode = MODE_CLEAR;
            end
            send_item(it);
        end
        settle();
    endtask

    // Hold results back for a long stretch while marks keep coming
    task automatic test_backpressure();
        tx_max   = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_item(mark_item(16'($urandom_range(0, 3000)), 16'($urandom), 0, 0,
                                10'($urandom)));
        end
        tx_max = 17;
        settle();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        rx_stall   = 1'b0;
        rx_took    = 1'b0;
        rx_gap     = 0;
        hold_req   = 1'b0;
        rx_max     = 17;
        tx_max     = 17;
        errors     = 0;
        cycles     = 0;
        cfg_m      = '{16'd65535, 16'd0, 16'd64, 24'sd0, 24'sd0, 16'd26, 8'd0, 8'd128};
        foreach (grid_m[k]) grid_m[k] = 8'd128;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random_scan(450, 26, 2560, 1'b0);
        test_backpressure();
        test_random_scan(450, 1, 120, 1'b0);
        test_random_scan(450, $urandom_range(2, 300), 9000, 1'b1);
        test_random_scan(420, $urandom_range(10, 60), 65535, 1'b0);

        i_valid = 1'b0;
        while (expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lom_pkg.sv
hw/rtl/lom_front.sv
hw/rtl/lom_queue.sv
hw/rtl/lom_back.sv
hw/rtl/lidar_occupancy_marker.sv
bench/tb_top.sv
